/* rtl/core/sbl_pkg.sv */
// sbl_pkg: shared constants, register codes and beat types of the sobel edge stream
// no dependencies; every other file of the block but sbl_if imports this package

package sbl_pkg;

    // line store geometry
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    // register and counter widths
    localparam int FW_W         = 12;
    localparam int FH_W         = 13;
    localparam int ROW_W        = 12;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int MIN_SIZE     = 3;
    localparam int CMP_W        = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;

    localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
    localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);

    // apb port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // bt.709 luma weights in 0.16 fixed point
    localparam int KR   = 13933;
    localparam int KG   = 46871;
    localparam int KB   = 4732;
    localparam int PR_W = 22;
    localparam int PG_W = 24;
    localparam int PB_W = 21;
    localparam int SUM_W = 24;

    localparam int PIX_W = 8;
    localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // register index taken from the word address
    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } sbl_reg_t;

    // per pixel classification carried down the front pipeline
    typedef struct packed {
        logic             prod;
        logic             border;
        logic             eol;
        logic             eof;
        logic [COL_W-1:0] idx;
    } sbl_tag_t;

    // one 3x3 neighborhood, px[row][col], plus result flags
    typedef struct packed {
        logic [2:0][2:0][PIX_W-1:0] px;
        logic                       border;
        logic                       eol;
        logic                       eof;
    } sbl_win_t;

    // queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } sbl_qstat_t;

endpackage

/* rtl/core/sbl_if.sv */
// sbl_if: valid/ready stream interfaces for rgb pixel beats and edge result beats
// depends on nothing; used by the top level and its testbench

interface sbl_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       start_of_frame;

    modport source (output valid, output red, output green, output blue,
                    output start_of_frame, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input start_of_frame, output ready);
endinterface

interface sbl_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] edge_res;
    logic       end_of_line;
    logic       end_of_frame;

    modport source (output valid, output edge_res, output end_of_line,
                    output end_of_frame, input ready);
    modport sink   (input valid, input edge_res, input end_of_line,
                    input end_of_frame, output ready);
endinterface

/* rtl/core/rgb_sobel_edge_stream.sv */
// Streaming 3x3 Sobel edge detector on RGB pixels in raster order. Each pixel beat
// is turned into BT.709 luma, a line store of MAX_WIDTH two-byte entries keeps the
// gray values of the two previous rows, and every pixel at row r >= 1, column c >= 1
// yields one result beat for center (r-1, c-1): min(255, |Gx| + |Gy|), or 0 on the
// border. The block takes one pixel per clock and returns one result per clock when
// the sink is ready; the pace is set by the line store, which does one read and one
// write per pixel with a bypass for a column hit twice in a row. With an empty queue
// and a ready sink a pixel's result beat becomes valid once it has passed two front
// register stages, the queue and the output register.
// A four-entry queue lets the front keep accepting while the sink stalls; pixel ready
// drops only when that queue is full. The line store is not cleared after reset; the
// first frame after reset starts at row 0, column 0, later frames start with
// start_of_frame or follow on by wrapping at the frame size. frame_width and
// frame_height (APB, byte addresses 0 and 4) may be written only while the block is idle.
// depends on sbl_pkg, sbl_if, sbl_cfg, sbl_front, sbl_fifo, sbl_back

module rgb_sobel_edge_stream
    import sbl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    sbl_pix_if.sink            pix,
    sbl_res_if.source          res
);

    logic [FW_W-1:0] frame_width;
    logic [FH_W-1:0] frame_height;
    logic            push;
    logic            pop;
    sbl_win_t        push_win;
    sbl_win_t        head;
    sbl_qstat_t      qstat;

    // configuration registers
    sbl_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .frame_width  (frame_width),
        .frame_height (frame_height)
    );

    // pixel intake and window assembly
    sbl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .pix          (pix),
        .qstat        (qstat),
        .push         (push),
        .push_win     (push_win)
    );

    // window queue
    sbl_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_win),
        .pop   (pop),
        .rdata (head),
        .qstat (qstat)
    );

    // gradient and result beat
    sbl_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .qstat (qstat),
        .pop   (pop),
        .res   (res)
    );

endmodule

/* rtl/core/sbl_cfg.sv */
// sbl_cfg: apb register file holding frame width and frame height
// depends on sbl_pkg

module sbl_cfg
    import sbl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [FW_W-1:0]    frame_width,
    output logic [FH_W-1:0]    frame_height
);

    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    logic            wr_en;
    sbl_reg_t        sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = sbl_reg_t'(paddr[2]);

    // register writes, low address bits ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_FRAME_WIDTH:  width_reg  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= pwdata[FH_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (sel)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    assign frame_width  = width_reg;
    assign frame_height = height_reg;

endmodule

/* rtl/core/sbl_front.sv */
// sbl_front: pixel intake, position counters, luma, line stores and window assembly
// depends on sbl_pkg; pushes complete 3x3 windows into the queue

module sbl_front
    import sbl_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [FW_W-1:0] frame_width,
    input  logic [FH_W-1:0] frame_height,
    sbl_pix_if.sink         pix,
    input  sbl_qstat_t      qstat,
    output logic            push,
    output sbl_win_t        push_win
);

    logic                 en;
    logic                 acc;
    logic [CMP_W-1:0]     fw_ext;
    logic [CMP_W-1:0]     w_use;
    logic [FH_W-1:0]      h_use;
    logic [COL_W-1:0]     col_raw;
    logic [ROW_W-1:0]     row_raw;
    logic [COL_W-1:0]     c;
    logic [ROW_W-1:0]     r;
    logic                 last_col;
    logic                 last_row;
    sbl_tag_t             tag0;

    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;

    logic                 s1_valid_reg;
    sbl_tag_t             s1_tag_reg;
    logic [PR_W-1:0]      s1_pr_reg;
    logic [PG_W-1:0]      s1_pg_reg;
    logic [PB_W-1:0]      s1_pb_reg;
    logic [SUM_W-1:0]     luma_sum;
    logic [PIX_W-1:0]     gray1;

    logic                 s2_valid_reg;
    sbl_tag_t             s2_tag_reg;
    logic [PIX_W-1:0]     s2_gray_reg;
    logic                 s2_fwd_reg;
    logic [PIX_W-1:0]     s2_ftop_reg;
    logic [PIX_W-1:0]     s2_fmid_reg;
    logic [2*PIX_W-1:0]   rd_reg;
    logic [PIX_W-1:0]     top_eff;
    logic [PIX_W-1:0]     mid_eff;

    logic [5:0][PIX_W-1:0] win_reg;

    // upper byte: row r-2, lower byte: row r-1
    logic [2*PIX_W-1:0]   line_mem [MAX_WIDTH];

    // the whole front advances while the queue has room
    assign en        = !qstat.full;
    assign pix.ready = en;
    assign acc       = pix.valid && en;

    // sizes in use, saturated to their legal ranges
    assign fw_ext = CMP_W'(frame_width);
    always_comb
    begin
        if (fw_ext < CMP_W'(MIN_SIZE))
            w_use = CMP_W'(MIN_SIZE);
        else if (fw_ext > CMP_W'(MAX_WIDTH))
            w_use = CMP_W'(MAX_WIDTH);
        else
            w_use = fw_ext;

        if (frame_height < FH_W'(MIN_SIZE))
            h_use = FH_W'(MIN_SIZE);
        else if (frame_height > FH_W'(HEIGHT_LIMIT))
            h_use = FH_W'(HEIGHT_LIMIT);
        else
            h_use = frame_height;
    end

    // position of this beat, clamped when the frame size shrank
    assign col_raw = pix.start_of_frame ? '0 : col_reg;
    assign row_raw = pix.start_of_frame ? '0 : row_reg;

    always_comb
    begin
        if (CMP_W'(col_raw) >= w_use)
            c = COL_W'(w_use - CMP_W'(1));
        else
            c = col_raw;

        if (FH_W'(row_raw) >= h_use)
            r = ROW_W'(h_use - FH_W'(1));
        else
            r = row_raw;
    end

    assign last_col = (CMP_W'(c) == w_use - CMP_W'(1));
    assign last_row = (FH_W'(r) == h_use - FH_W'(1));

    // classification
    always_comb
    begin
        tag0.prod   = (r != '0) && (c != '0);
        tag0.border = (r[ROW_W-1:1] == '0) || (c[COL_W-1:1] == '0);
        tag0.eol    = last_col;
        tag0.eof    = last_col && last_row;
        tag0.idx    = c;
    end

    // counter advance
    always_comb
    begin
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : r + ROW_W'(1);
        end
        else
        begin
            col_next = c + COL_W'(1);
            row_next = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1: weighted color products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= acc;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_tag_reg <= tag0;
            s1_pr_reg  <= PR_W'(pix.red)   * PR_W'(KR);
            s1_pg_reg  <= PG_W'(pix.green) * PG_W'(KG);
            s1_pb_reg  <= PB_W'(pix.blue)  * PB_W'(KB);
        end
    end

    assign luma_sum = SUM_W'(s1_pr_reg) + SUM_W'(s1_pg_reg) + SUM_W'(s1_pb_reg);
    assign gray1    = luma_sum[SUM_W-1:SUM_W-PIX_W];

    // stage 2: line store read, bypass when the previous beat hits the same column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_tag_reg  <= s1_tag_reg;
            s2_gray_reg <= gray1;
            s2_fwd_reg  <= s2_valid_reg && (s2_tag_reg.idx == s1_tag_reg.idx);
            s2_ftop_reg <= mid_eff;
            s2_fmid_reg <= s2_gray_reg;
        end
    end

    // line store: one read and one write per beat
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_reg <= line_mem[s1_tag_reg.idx];
            if (s2_valid_reg)
                line_mem[s2_tag_reg.idx] <= {mid_eff, s2_gray_reg};
        end
    end

    assign top_eff = s2_fwd_reg ? s2_ftop_reg : rd_reg[2*PIX_W-1:PIX_W];
    assign mid_eff = s2_fwd_reg ? s2_fmid_reg : rd_reg[PIX_W-1:0];

    // two previous columns of the neighborhood
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (en && s2_valid_reg)
            win_reg <= {s2_gray_reg, mid_eff, top_eff, win_reg[5:3]};
    end

    // window out to the queue
    assign push = en && s2_valid_reg && s2_tag_reg.prod;

    always_comb
    begin
        push_win.px[0][0] = win_reg[0];
        push_win.px[1][0] = win_reg[1];
        push_win.px[2][0] = win_reg[2];
        push_win.px[0][1] = win_reg[3];
        push_win.px[1][1] = win_reg[4];
        push_win.px[2][1] = win_reg[5];
        push_win.px[0][2] = top_eff;
        push_win.px[1][2] = mid_eff;
        push_win.px[2][2] = s2_gray_reg;
        push_win.border   = s2_tag_reg.border;
        push_win.eol      = s2_tag_reg.eol;
        push_win.eof      = s2_tag_reg.eof;
    end

endmodule

/* rtl/core/sbl_fifo.sv */
// sbl_fifo: short window queue between front and back
// depends on sbl_pkg

module sbl_fifo
    import sbl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  sbl_win_t   wdata,
    input  logic       pop,
    output sbl_win_t   rdata,
    output sbl_qstat_t qstat
);

    sbl_win_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign qstat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign rdata       = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

`ifndef SYNTHESIS
    // front only pushes while there is room
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !qstat.full)
        else $error("window queue overflow");

    // back only pops a stored window
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !qstat.empty)
        else $error("window queue underflow");

    // fill level follows the pointers
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("window queue pointers disagree with fill level");
`endif

endmodule

/* rtl/core/sbl_back.sv */
// sbl_back: sobel gradient, magnitude and output register
// depends on sbl_pkg; pops windows from the queue, drives the result stream

module sbl_back
    import sbl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sbl_win_t   head,
    input  sbl_qstat_t qstat,
    output logic       pop,
    sbl_res_if.source  res
);

    logic [PIX_W+1:0]        left_sum, right_sum, top_sum, bot_sum;
    logic signed [PIX_W+2:0] gx, gy;
    logic [PIX_W+1:0]        gx_abs, gy_abs;
    logic [PIX_W+2:0]        mag;
    logic [PIX_W-1:0]        edge_val;

    logic                    out_valid_reg;
    logic [PIX_W-1:0]        out_edge_reg;
    logic                    out_eol_reg;
    logic                    out_eof_reg;

    // column and row weighted sums
    always_comb
    begin
        left_sum  = (PIX_W+2)'(head.px[0][0]) + {1'b0, head.px[1][0], 1'b0}
                  + (PIX_W+2)'(head.px[2][0]);
        right_sum = (PIX_W+2)'(head.px[0][2]) + {1'b0, head.px[1][2], 1'b0}
                  + (PIX_W+2)'(head.px[2][2]);
        top_sum   = (PIX_W+2)'(head.px[0][0]) + {1'b0, head.px[0][1], 1'b0}
                  + (PIX_W+2)'(head.px[0][2]);
        bot_sum   = (PIX_W+2)'(head.px[2][0]) + {1'b0, head.px[2][1], 1'b0}
                  + (PIX_W+2)'(head.px[2][2]);
    end

    // gradients and saturated |gx| + |gy|
    always_comb
    begin
        gx     = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});
        gy     = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});
        gx_abs = gx[PIX_W+2] ? (PIX_W+2)'(-gx) : gx[PIX_W+1:0];
        gy_abs = gy[PIX_W+2] ? (PIX_W+2)'(-gy) : gy[PIX_W+1:0];
        mag    = (PIX_W+3)'(gx_abs) + (PIX_W+3)'(gy_abs);
        if (head.border)
            edge_val = '0;
        else if (mag > (PIX_W+3)'(EDGE_MAX))
            edge_val = EDGE_MAX;
        else
            edge_val = mag[PIX_W-1:0];
    end

    // output register takes a new window whenever it is free or being drained
    assign pop = !qstat.empty && (!out_valid_reg || res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || res.ready)
            out_valid_reg <= pop;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_edge_reg <= edge_val;
            out_eol_reg  <= head.eol;
            out_eof_reg  <= head.eof;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.edge_res     = out_edge_reg;
    assign res.end_of_line  = out_eol_reg;
    assign res.end_of_frame = out_eof_reg;

endmodule

/* tb/testbench.sv */
// testbench for rgb_sobel_edge_stream: rgb pixel beats in, sobel edge beats out, apb setup
// depends on sbl_pkg, sbl_if and the rtl; runs its own luma and sobel predictor per pixel
`timescale 1ns / 1ps

module testbench
    import sbl_pkg::*;
();

    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          IDLE_PCT    = 16;
    localparam int          DRAIN_WAIT  = 8;
    localparam int unsigned LUMA_R      = 13933;
    localparam int unsigned LUMA_G      = 46871;
    localparam int unsigned LUMA_B      = 4732;
    localparam int unsigned ROWS_LIMIT  = 4096;

    // one expected result beat
    typedef struct packed {
        logic [7:0] strength;
        logic       eol;
        logic       eof;
    } edge_beat_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    sbl_pix_if pix_bus ();
    sbl_res_if res_bus ();

    rgb_sobel_edge_stream dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix     (pix_bus),
        .res     (res_bus)
    );

    // predictor state: register copies, line stores, window and raster position
    logic [FW_W-1:0] width_reg  = 12'd640;
    logic [FH_W-1:0] height_reg = 13'd480;
    logic [7:0]      upper_row [MAX_WIDTH];
    logic [7:0]      lower_row [MAX_WIDTH];
    int              win_px [6];
    int unsigned     col_pos;
    int unsigned     row_pos;

    edge_beat_t  edge_pending [$];
    int unsigned fault_count = 0;
    int unsigned cycle_count = 0;
    logic        steady      = 1'b0;

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result sink backpressure
    always @(negedge clk)
    begin
        res_bus.ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // compare every accepted result beat with the oldest expectation
    always @(posedge clk)
    begin
        edge_beat_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (edge_pending.size() == 0)
            begin
                $display("%0t: unexpected result beat: expected none, actual %0d/%0b/%0b",
                         $time, res_bus.edge_res, res_bus.end_of_line, res_bus.end_of_frame);
                fault_count++;
            end
            else
            begin
                want = edge_pending.pop_front();
                if (res_bus.edge_res !== want.strength)
                begin
                    $display("%0t: edge_res mismatch: expected %0d, actual %0d",
                             $time, want.strength, res_bus.edge_res);
                    fault_count++;
                end
                if (res_bus.end_of_line !== want.eol)
                begin
                    $display("%0t: end_of_line mismatch: expected %0b, actual %0b",
                             $time, want.eol, res_bus.end_of_line);
                    fault_count++;
                end
                if (res_bus.end_of_frame !== want.eof)
                begin
                    $display("%0t: end_of_frame mismatch: expected %0b, actual %0b",
                             $time, want.eof, res_bus.end_of_frame);
                    fault_count++;
                end
            end
        end
    end

    // sizes after saturation
    function automatic int unsigned width_in_use();
        int unsigned w;
        w = width_reg;
        if (w < MIN_SIZE)
            w = MIN_SIZE;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned height_in_use();
        int unsigned h;
        h = height_reg;
        if (h < MIN_SIZE)
            h = MIN_SIZE;
        if (h > ROWS_LIMIT)
            h = ROWS_LIMIT;
        return h;
    endfunction

    // advance the predictor by one pixel and queue the edge beat it yields
    function automatic void predict_edge(input logic [7:0] r8, input logic [7:0] g8,
                                         input logic [7:0] b8, input logic sof);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int          luma;
        int          top;
        int          mid;
        int          gx;
        int          gy;
        int          mag;
        edge_beat_t  beat;
        w = width_in_use();
        h = height_in_use();
        if (sof)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        luma = int'((LUMA_R * r8 + LUMA_G * g8 + LUMA_B * b8) >> 16);
        top = upper_row[c];
        mid = lower_row[c];
        upper_row[c] = mid[7:0];
        lower_row[c] = luma[7:0];
        if (r >= 1 && c >= 1)
        begin
            mag = 0;
            // full window only once two rows and two columns are behind us
            if (r >= 2 && c >= 2)
            begin
                gx = (win_px[0] + 2 * win_px[1] + win_px[2]) - (top + 2 * mid + luma);
                gy = (win_px[0] + 2 * win_px[3] + top) - (win_px[2] + 2 * win_px[5] + luma);
                if (gx < 0)
                    gx = -gx;
                if (gy < 0)
                    gy = -gy;
                mag = (gx + gy > 255) ? 255 : gx + gy;
            end
            beat.strength = mag[7:0];
            beat.eol      = (c == w - 1);
            beat.eof      = (c == w - 1) && (r == h - 1);
            edge_pending.push_back(beat);
        end
        win_px[0] = win_px[3];
        win_px[1] = win_px[4];
        win_px[2] = win_px[5];
        win_px[3] = top;
        win_px[4] = mid;
        win_px[5] = luma;
        // raster advance with wrap at row and frame end
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    // one pixel beat, with random source gaps
    task automatic send_pixel(input logic [7:0] r8, input logic [7:0] g8,
                              input logic [7:0] b8, input logic sof);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            pix_bus.valid <= 1'b0;
            @(negedge clk);
        end
        pix_bus.valid          <= 1'b1;
        pix_bus.red            <= r8;
        pix_bus.green          <= g8;
        pix_bus.blue           <= b8;
        pix_bus.start_of_frame <= sof;
        do
            @(posedge clk);
        while (!pix_bus.ready);
        predict_edge(r8, g8, b8, sof);
    endtask

    // stop sending, let every expected beat arrive, then cover the pipeline latency
    task automatic wait_drained();
        @(negedge clk);
        pix_bus.valid <= 1'b0;
        while (edge_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // apb read, compared with the expected register value
    task automatic check_reg(input sbl_reg_t sel, input logic [PDATA_W-1:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            $display("%0t: register %s readback mismatch: expected %0d, actual %0d",
                     $time, sel.name(), want, prdata);
            fault_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // apb write, mirrored into the predictor and read back
    task automatic write_reg(input sbl_reg_t sel, input logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (sel == REG_FRAME_WIDTH)
            width_reg = value[FW_W-1:0];
        else
            height_reg = value[FH_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_reg(sel, (sel == REG_FRAME_WIDTH) ? PDATA_W'(width_reg) : PDATA_W'(height_reg));
    endtask

    function automatic logic [7:0] pick_channel(input logic smooth, input int unsigned base);
        if (smooth)
            return 8'(base + $urandom_range(15));
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // stream of random pixels, start of frame on the first one only if asked
    task automatic send_noise(input int unsigned count, input logic sof_first);
        for (int unsigned i = 0; i < count; i++)
            send_pixel(pick_channel(1'b0, 0), pick_channel(1'b0, 0), pick_channel(1'b0, 0),
                       sof_first && i == 0);
    endtask

    // reset values, and a first frame that starts right after reset without a marker
    task automatic test_reset_defaults();
        check_reg(REG_FRAME_WIDTH, 32'd640);
        check_reg(REG_FRAME_HEIGHT, 32'd480);
        write_reg(REG_FRAME_WIDTH, 32'd4);
        write_reg(REG_FRAME_HEIGHT, 32'd4);
        send_noise(4 * 4 + 2, 1'b0);
    endtask

    // pure color primaries, white and black, to pin down the luma weights and saturation
    task automatic test_color_weights();
        logic [7:0] rr [4];
        logic [7:0] gg [4];
        logic [7:0] bb [4];
        rr = '{8'd255, 8'd0, 8'd0, 8'd255};
        gg = '{8'd0, 8'd255, 8'd0, 8'd255};
        bb = '{8'd0, 8'd0, 8'd255, 8'd255};
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 32'd4);
        write_reg(REG_FRAME_HEIGHT, 32'd4);
        for (int row = 0; row < 4; row++)
            for (int col = 0; col < 4; col++)
                if ((row + col) % 2 == 0)
                    send_pixel(rr[col], gg[col], bb[col], row == 0 && col == 0);
                else
                    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    endtask

    // all-zero sizes saturate to the three by three minimum
    task automatic test_size_floor();
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 32'd0);
        write_reg(REG_FRAME_HEIGHT, 32'd0);
        send_noise(9, 1'b1);
    endtask

    // frames back to back without marker, repeated and mid-row start of frame
    task automatic test_frame_wrap();
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 32'd3);
        write_reg(REG_FRAME_HEIGHT, 32'd3);
        send_noise(18, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd12, 8'd200, 8'd7, 1'b1);
        send_noise(8, 1'b0);
    endtask

    // sizes lowered under the running position: column and row clamp to the last one
    task automatic test_lowered_size();
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 32'd5);
        write_reg(REG_FRAME_HEIGHT, 32'd4);
        send_noise(18, 1'b1);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 32'd3);
        write_reg(REG_FRAME_HEIGHT, 32'd3);
        send_noise(1 + 9, 1'b0);
    endtask

    // long stretch with no idling on either side, full rate through the queue
    task automatic test_steady_stream();
        wait_drained();
        steady = 1'b1;
        write_reg(REG_FRAME_WIDTH, 32'd64);
        write_reg(REG_FRAME_HEIGHT, 32'd4);
        send_noise(64 * 4, 1'b1);
        steady = 1'b0;
    endtask

    // height saturated on the narrowest rows: no frame end in the early rows
    task automatic test_tall_frame();
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 32'd2);
        write_reg(REG_FRAME_HEIGHT, 32'd8191);
        send_noise(3 * 5, 1'b1);
    endtask

    // random sizes and images, mostly whole frames, some stray or missing frame starts
    task automatic test_random_frames();
        int unsigned sent;
        int unsigned w_set;
        int unsigned h_set;
        int unsigned pixels;
        int unsigned frames;
        int unsigned base;
        int          phase;
        logic        smooth;
        logic        sof;
        sent  = 0;
        phase = 0;
        while (sent < 600)
        begin
            wait_drained();
            steady = (phase == 2);
            case ($urandom_range(9))
                0: w_set = $urandom_range(0, 2);
                1: w_set = $urandom_range(13, 40);
                default: w_set = $urandom_range(3, 12);
            endcase
            case ($urandom_range(9))
                0: h_set = $urandom_range(0, 2);
                1: h_set = $urandom_range(9, 20);
                default: h_set = $urandom_range(3, 8);
            endcase
            write_reg(REG_FRAME_WIDTH, w_set);
            write_reg(REG_FRAME_HEIGHT, h_set);
            pixels = width_in_use() * height_in_use();
            frames = $urandom_range(1, 3);
            for (int unsigned f = 0; f < frames; f++)
            begin
                smooth = $urandom_range(1);
                base   = $urandom_range(240);
                for (int unsigned p = 0; p < pixels; p++)
                begin
                    sof = (p == 0) && (f == 0 || $urandom_range(99) < 60);
                    // stray frame start or abandoned frame now and then
                    if (p != 0 && $urandom_range(99) < 2)
                        sof = 1'b1;
                    if (p != 0 && $urandom_range(199) == 0)
                        break;
                    // sender holds off until every result is back
                    if ($urandom_range(299) == 0)
                        wait_drained();
                    send_pixel(pick_channel(smooth, base), pick_channel(smooth, base),
                               pick_channel(smooth, base), sof);
                    sent++;
                end
            end
            phase++;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        pix_bus.valid          = 1'b0;
        pix_bus.red            = '0;
        pix_bus.green          = '0;
        pix_bus.blue           = '0;
        pix_bus.start_of_frame = 1'b0;
        res_bus.ready          = 1'b0;
        col_pos                = 0;
        row_pos                = 0;
        for (int i = 0; i < 6; i++)
            win_px[i] = 0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            upper_row[i] = '0;
            lower_row[i] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_color_weights();
        test_size_floor();
        test_frame_wrap();
        test_lowered_size();
        test_steady_stream();
        test_tall_frame();
        test_random_frames();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/sbl_pkg.sv
rtl/core/sbl_if.sv
rtl/core/sbl_cfg.sv
rtl/core/sbl_front.sv
rtl/core/sbl_fifo.sv
rtl/core/sbl_back.sv
rtl/core/rgb_sobel_edge_stream.sv
tb/testbench.sv
